>>> design/double_prefix_hash_substring_query_defines.svh
// Assertion macros used by the double prefix hash top level.
`ifndef DOUBLE_PREFIX_HASH_SUBSTRING_QUERY_DEFINES_SVH
`define DOUBLE_PREFIX_HASH_SUBSTRING_QUERY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DPHS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DPHS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dphs_pkg.sv
// Shared widths, moduli, codes and types of the double prefix hash block.
package dphs_pkg;

    localparam int HASH_W    = 30;
    localparam int CH_W      = 7;
    localparam int IDX_W     = 12;
    localparam int CFG_IDX_W = 1;

    localparam int unsigned DPHS_MAX_LEN = 4096;

    localparam logic [HASH_W-1:0] MOD_A       = 30'd1000000009;
    localparam logic [HASH_W-1:0] MOD_B       = 30'd1000000007;
    localparam logic [HASH_W-1:0] BASE_A_RST  = 30'd31;
    localparam logic [HASH_W-1:0] BASE_B_RST  = 30'd1337;
    localparam logic [HASH_W-1:0] LETTER_OFS  = 30'd96;
    localparam logic [HASH_W-1:0] HASH_ONE    = 30'd1;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_B = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_READ_E = 7'b0000010,
        S_READ_S = 7'b0000100,
        S_LOAD   = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_WRITE  = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

endpackage

>>> design/double_prefix_hash_substring_query.sv
// Top level: double polynomial prefix hash store with substring hash queries.
//
//  channel   | ports                                          | handshake
//  ----------+------------------------------------------------+---------------------------
//  request   | op, restart, ch, start_index, end_index        | start high, busy low
//  result    | hash_a, hash_b, range_error                    | done strobe, one cycle
//  config    | cfg_index, cfg_data                            | cfg_we, taken every edge
//
//  A query with start_index above zero and an append past position 0 both run
//  the 30-step bit-serial modular multiplier; an append at position 0, a query
//  from position 0, an out-of-range query and a dropped append do not use it.
//  Reset clears the length and loads base_a = 31, base_b = 1337; the tables are
//  not cleared, only entries below the loaded length are ever used.
//  done pulses for one cycle; the receiver cannot stall it.
`include "double_prefix_hash_substring_query_defines.svh"

module double_prefix_hash_substring_query
    import dphs_pkg::*;
#(
    parameter int unsigned MAX_LEN = DPHS_MAX_LEN
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 op,
    input  logic                 restart,
    input  logic [CH_W-1:0]      ch,
    input  logic [IDX_W-1:0]     start_index,
    input  logic [IDX_W-1:0]     end_index,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HASH_W-1:0]    cfg_data,
    output logic                 done,
    output logic [HASH_W-1:0]    hash_a,
    output logic [HASH_W-1:0]    hash_b,
    output logic                 range_error
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = (LW > IDX_W) ? LW : IDX_W;

    // (a + b) mod m for a, b below m
    function automatic logic [HASH_W-1:0] add_mod(input logic [HASH_W-1:0] a,
                                                  input logic [HASH_W-1:0] b,
                                                  input logic [HASH_W-1:0] m);
        logic [HASH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, m}) ? HASH_W'(s - {1'b0, m}) : s[HASH_W-1:0];
    endfunction

    // (a - b) mod m for a, b below m
    function automatic logic [HASH_W-1:0] sub_mod(input logic [HASH_W-1:0] a,
                                                  input logic [HASH_W-1:0] b,
                                                  input logic [HASH_W-1:0] m);
        return (a >= b) ? (a - b) : (a + (m - b));
    endfunction

    // (ch - 96) mod m; letters below the offset wrap to the top of the range
    function automatic logic [HASH_W-1:0] letter_mod(input logic [CH_W-1:0]   c,
                                                     input logic [HASH_W-1:0] m);
        logic [HASH_W-1:0] cz;
        cz = HASH_W'(c);
        return (cz >= LETTER_OFS) ? (cz - LETTER_OFS) : (m - (LETTER_OFS - cz));
    endfunction

    state_t            state_reg;
    state_t            state_next;
    logic [LW-1:0]     len_reg;
    logic [HASH_W-1:0] base_a_reg;
    logic [HASH_W-1:0] base_b_reg;
    logic              done_reg;

    logic              op_reg;
    logic [CH_W-1:0]   ch_reg;
    logic              first_reg;
    logic              s_zero_reg;
    logic [AW-1:0]     wr_addr_reg;
    logic [AW-1:0]     rd_addr_reg;
    logic [AW-1:0]     pw_addr_reg;
    logic [AW-1:0]     e_addr_reg;
    logic [HASH_W-1:0] pe_a_reg;
    logic [HASH_W-1:0] pe_b_reg;
    logic [HASH_W-1:0] hash_a_reg;
    logic [HASH_W-1:0] hash_b_reg;
    logic              err_reg;

    logic              accept;
    logic [LW-1:0]     p_eff;
    logic [LW-1:0]     p_m1;
    logic              app_full;
    logic [CW-1:0]     s_ext;
    logic [CW-1:0]     e_ext;
    logic [CW-1:0]     len_ext;
    logic [CW-1:0]     s_m1;
    logic [CW-1:0]     pw_idx;
    logic              q_bad;

    logic [HASH_W-1:0] base_a_red;
    logic [HASH_W-1:0] base_b_red;
    logic [AW-1:0]     pre_raddr;
    logic              tbl_we;
    logic [HASH_W-1:0] pre_a_rdata;
    logic [HASH_W-1:0] pre_b_rdata;
    logic [HASH_W-1:0] pow_a_rdata;
    logic [HASH_W-1:0] pow_b_rdata;
    logic [HASH_W-1:0] pre_a_wdata;
    logic [HASH_W-1:0] pre_b_wdata;
    logic [HASH_W-1:0] pow_a_wdata;
    logic [HASH_W-1:0] pow_b_wdata;
    logic [HASH_W-1:0] let_a;
    logic [HASH_W-1:0] let_b;

    logic              mul_go;
    logic [HASH_W-1:0] y_pa;
    logic [HASH_W-1:0] y_pb;
    logic [HASH_W-1:0] prod_pa;
    logic [HASH_W-1:0] prod_pb;
    logic [HASH_W-1:0] prod_wa;
    logic [HASH_W-1:0] prod_wb;
    logic              mul_done_pa;
    logic              mul_done_pb;
    logic              mul_done_wa;
    logic              mul_done_wb;

    // ---------------- request decode ----------------
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // a restart clears the length before the append lands
    assign p_eff    = restart ? '0 : len_reg;
    assign p_m1     = p_eff - LW'(1);
    assign app_full = (p_eff == LW'(MAX_LEN));

    assign s_ext   = CW'(start_index);
    assign e_ext   = CW'(end_index);
    assign len_ext = CW'(len_reg);
    assign s_m1    = s_ext - CW'(1);
    assign pw_idx  = e_ext - s_ext + CW'(1);
    assign q_bad   = (s_ext > e_ext) || (e_ext >= len_ext);

    // bases may be written up to 2^30-1, which is below twice either modulus
    assign base_a_red = (base_a_reg >= MOD_A) ? (base_a_reg - MOD_A) : base_a_reg;
    assign base_b_red = (base_b_reg >= MOD_B) ? (base_b_reg - MOD_B) : base_b_reg;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_APPEND)
                    begin
                        if (app_full)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (p_eff == '0)
                        begin
                            state_next = S_WRITE;
                        end
                        else
                        begin
                            state_next = S_READ_S;
                        end
                    end
                    else if (!q_bad)
                    begin
                        state_next = S_READ_E;
                    end
                end
            end
            S_READ_E: state_next = S_READ_S;
            S_READ_S:
            begin
                // a query from position 0 needs no product
                if (op_reg == OP_QUERY && s_zero_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:   state_next = S_MUL;
            S_MUL:
            begin
                if (mul_done_pa)
                begin
                    state_next = (op_reg == OP_APPEND) ? S_WRITE : S_OUT;
                end
            end
            S_WRITE:  state_next = S_IDLE;
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // control state: sequencer, length, bases, result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            base_a_reg <= BASE_A_RST;
            base_b_reg <= BASE_B_RST;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BASE_A: base_a_reg <= cfg_data;
                    REG_BASE_B: base_b_reg <= cfg_data;
                    default:    ;
                endcase
            end

            // restart clears the length on acceptance, so an append with restart is never dropped as full
            if (accept && op == OP_APPEND && restart)
            begin
                len_reg <= '0;
            end
            else if (state_reg == S_WRITE)
            begin
                len_reg <= LW'(wr_addr_reg) + LW'(1);
            end

            done_reg <= (accept && op == OP_QUERY && q_bad) || (state_reg == S_OUT);
        end
    end

    // payload: captured request, addresses, held prefix and result values
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op;
            ch_reg      <= ch;
            first_reg   <= (p_eff == '0);
            s_zero_reg  <= (start_index == '0);
            wr_addr_reg <= p_eff[AW-1:0];
            e_addr_reg  <= e_ext[AW-1:0];
            if (op == OP_APPEND)
            begin
                rd_addr_reg <= p_m1[AW-1:0];
                pw_addr_reg <= p_m1[AW-1:0];
            end
            else
            begin
                rd_addr_reg <= s_m1[AW-1:0];
                pw_addr_reg <= pw_idx[AW-1:0];
            end
        end

        // hold prefix[end] while the second read goes out
        if (state_reg == S_READ_S)
        begin
            pe_a_reg <= pre_a_rdata;
            pe_b_reg <= pre_b_rdata;
        end

        if (accept && op == OP_QUERY && q_bad)
        begin
            hash_a_reg <= '0;
            hash_b_reg <= '0;
            err_reg    <= 1'b1;
        end
        else if (state_reg == S_OUT)
        begin
            hash_a_reg <= s_zero_reg ? pe_a_reg : sub_mod(pe_a_reg, prod_pa, MOD_A);
            hash_b_reg <= s_zero_reg ? pe_b_reg : sub_mod(pe_b_reg, prod_pb, MOD_B);
            err_reg    <= 1'b0;
        end
    end

    // ---------------- tables ----------------
    assign pre_raddr = (state_reg == S_READ_E) ? e_addr_reg : rd_addr_reg;
    assign tbl_we    = (state_reg == S_WRITE);

    assign let_a = letter_mod(ch_reg, MOD_A);
    assign let_b = letter_mod(ch_reg, MOD_B);

    // position 0 seeds power with one and prefix with the letter
    assign pow_a_wdata = first_reg ? HASH_ONE : prod_wa;
    assign pow_b_wdata = first_reg ? HASH_ONE : prod_wb;
    assign pre_a_wdata = first_reg ? let_a : add_mod(prod_pa, let_a, MOD_A);
    assign pre_b_wdata = first_reg ? let_b : add_mod(prod_pb, let_b, MOD_B);

    dphs_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_pre_a
    (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (wr_addr_reg),
        .wdata (pre_a_wdata),
        .raddr (pre_raddr),
        .rdata (pre_a_rdata)
    );

    dphs_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_pre_b
    (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (wr_addr_reg),
        .wdata (pre_b_wdata),
        .raddr (pre_raddr),
        .rdata (pre_b_rdata)
    );

    dphs_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_pow_a
    (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (wr_addr_reg),
        .wdata (pow_a_wdata),
        .raddr (pw_addr_reg),
        .rdata (pow_a_rdata)
    );

    dphs_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_pow_b
    (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (wr_addr_reg),
        .wdata (pow_b_wdata),
        .raddr (pw_addr_reg),
        .rdata (pow_b_rdata)
    );

    // ---------------- multipliers ----------------
    // Prefix units: prefix*base on append, prefix[start-1]*power[end-start+1] on query.
    // Power units: power*base; they start with the prefix units so all four finish together.
    assign mul_go = (state_reg == S_LOAD);
    assign y_pa   = (op_reg == OP_QUERY) ? pow_a_rdata : base_a_red;
    assign y_pb   = (op_reg == OP_QUERY) ? pow_b_rdata : base_b_red;

    dphs_mulmod #(.MODULUS(MOD_A)) u_mul_pa
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (mul_go),
        .x       (pre_a_rdata),
        .y       (y_pa),
        .product (prod_pa),
        .done    (mul_done_pa)
    );

    dphs_mulmod #(.MODULUS(MOD_B)) u_mul_pb
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (mul_go),
        .x       (pre_b_rdata),
        .y       (y_pb),
        .product (prod_pb),
        .done    (mul_done_pb)
    );

    dphs_mulmod #(.MODULUS(MOD_A)) u_mul_wa
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (mul_go),
        .x       (pow_a_rdata),
        .y       (base_a_red),
        .product (prod_wa),
        .done    (mul_done_wa)
    );

    dphs_mulmod #(.MODULUS(MOD_B)) u_mul_wb
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (mul_go),
        .x       (pow_b_rdata),
        .y       (base_b_red),
        .product (prod_wb),
        .done    (mul_done_wb)
    );

    // ---------------- result ----------------
    assign done        = done_reg;
    assign hash_a      = hash_a_reg;
    assign hash_b      = hash_b_reg;
    assign range_error = err_reg;

    // ---------------- assertions ----------------
    `DPHS_ASSERT_IMP(a_err_hash_zero, done_reg && err_reg,
        hash_a_reg == '0 && hash_b_reg == '0, "range error result carries nonzero hash")
    `DPHS_ASSERT_IMP(a_done_source, done_reg,
        $past(state_reg == S_OUT) || $past(accept && op == OP_QUERY && q_bad),
        "result strobe without a query behind it")
    `DPHS_ASSERT_IMP(a_mul_lockstep, mul_done_pa,
        mul_done_pb && mul_done_wa && mul_done_wb, "multipliers finished out of step")
    `DPHS_ASSERT_NXT(a_mul_wait, state_reg == S_MUL && !mul_done_pa,
        state_reg == S_MUL, "left multiply before the product was ready")
    `DPHS_ASSERT_NXT(a_len_after_write, state_reg == S_WRITE,
        len_reg != '0 && len_reg <= LW'(MAX_LEN), "length out of range after append")

endmodule

>>> design/dphs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dphs_ram
#(
    parameter int WIDTH = 30,
    parameter int DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/dphs_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
module dphs_mulmod
    import dphs_pkg::*;
#(
    parameter logic [HASH_W-1:0] MODULUS = MOD_A
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [HASH_W-1:0] x,
    input  logic [HASH_W-1:0] y,
    output logic [HASH_W-1:0] product,
    output logic              done
);

    localparam int CNT_W = $clog2(HASH_W + 1);

    logic [HASH_W-1:0] acc_reg;
    logic [HASH_W-1:0] acc_next;
    logic [HASH_W-1:0] x_reg;
    logic [HASH_W-1:0] y_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [HASH_W:0]   dbl;
    logic [HASH_W:0]   sum;
    logic [HASH_W-1:0] dbl_red;

    // Horner step: acc = 2*acc + bit*x, each add folded back below the modulus
    assign dbl     = {acc_reg, 1'b0};
    assign dbl_red = (dbl >= {1'b0, MODULUS}) ? HASH_W'(dbl - {1'b0, MODULUS})
                                              : dbl[HASH_W-1:0];
    assign sum      = {1'b0, dbl_red} + (y_reg[HASH_W-1] ? {1'b0, x_reg} : '0);
    assign acc_next = (sum >= {1'b0, MODULUS}) ? HASH_W'(sum - {1'b0, MODULUS})
                                               : sum[HASH_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(HASH_W);
        end
        else if (run_reg)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            run_reg  <= (cnt_reg != CNT_W'(1));
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            acc_reg <= '0;
            x_reg   <= x;
            y_reg   <= y;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[HASH_W-2:0], 1'b0};
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule
